>>> rtl/core/three_level_priority_queue_unit_macros.svh
// Assertion helpers shared by the queue RTL.
// Every property is clocked on i_clk and is disabled while i_rst_n is low.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TLPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tlpq_pkg.sv
`timescale 1ns / 1ps
package tlpq_pkg;

    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int NUM_LEVELS       = 3;
    localparam int PRIO_BITS        = 2;
    localparam int WORD_BITS        = 32;
    localparam int STATUS_BITS      = 2;

    typedef logic [1:0] t_level;

    localparam t_level LVL_ONE   = 2'd0;
    localparam t_level LVL_TWO   = 2'd1;
    localparam t_level LVL_THREE = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;

    localparam logic [PRIO_BITS-1:0] PRIO_ONE = 2'd1;
    localparam logic [PRIO_BITS-1:0] PRIO_TWO = 2'd2;

    typedef struct packed {
        logic                 func;
        logic [PRIO_BITS-1:0] priority_req;
        logic [WORD_BITS-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   item_valid;
        logic [PRIO_BITS-1:0]   item_priority;
        logic [WORD_BITS-1:0]   item_payload;
    } t_out_item;

    typedef struct packed {
        logic accept_insert;
        logic accept_remove;
        logic load_read;
    } t_dp_cmd;

    typedef struct packed {
        logic any_item;
    } t_dp_stat;

    function automatic t_level level_of(input logic [PRIO_BITS-1:0] prio);
        t_level lvl;
        case (prio)
            PRIO_ONE: lvl = LVL_ONE;
            PRIO_TWO: lvl = LVL_TWO;
            default:  lvl = LVL_THREE;
        endcase
        return lvl;
    endfunction

endpackage

>>> rtl/core/tlpq_ram.sv
`timescale 1ns / 1ps
module tlpq_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tlpq_dp.sv
`timescale 1ns / 1ps
`include "three_level_priority_queue_unit_macros.svh"
module tlpq_dp #(
    parameter int LEVEL_DEPTH  = tlpq_pkg::LEVEL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tlpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlpq_pkg::t_dp_cmd   i_cmd,
    input  tlpq_pkg::t_in_item  i_in_data,
    output tlpq_pkg::t_dp_stat  o_stat,
    output tlpq_pkg::t_out_item o_out_data
);
    import tlpq_pkg::*;

    localparam int IW = $clog2(LEVEL_DEPTH + 1);
    localparam int AW = $clog2(LEVEL_DEPTH);
    localparam int EW = PRIO_BITS + PAYLOAD_BITS;
    localparam logic [IW-1:0] FULL_MARK = IW'(LEVEL_DEPTH);

    logic [IW-1:0]         r_wr [NUM_LEVELS];
    logic [IW-1:0]         n_wr [NUM_LEVELS];
    logic [IW-1:0]         r_rd [NUM_LEVELS];
    logic [IW-1:0]         n_rd [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] empty;
    logic                  any_item;
    logic                  ins_full;
    t_level                ins_lvl;
    t_level                sel;
    t_level                r_sel;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata [NUM_LEVELS];
    t_out_item             r_out;
    t_out_item             n_out;

    assign wdata = {i_in_data.priority_req, PAYLOAD_BITS'(i_in_data.payload)};

    always_comb begin
        ins_lvl = level_of(i_in_data.priority_req);
        for (int l = 0; l < NUM_LEVELS; l++) begin
            empty[l] = (r_wr[t_level'(l)] == r_rd[t_level'(l)]);
        end
        any_item = ~&empty;
        if (!empty[LVL_THREE]) begin
            sel = LVL_THREE;
        end else if (!empty[LVL_TWO]) begin
            sel = LVL_TWO;
        end else begin
            sel = LVL_ONE;
        end
        ins_full = (r_wr[ins_lvl] == FULL_MARK);

        n_wr  = r_wr;
        n_rd  = r_rd;
        n_out = r_out;

        if (i_cmd.accept_insert) begin
            n_out = '0;
            if (ins_full) begin
                n_out.status = ST_FULL;
            end else begin
                n_out.status = ST_OK;
                n_wr[ins_lvl] = r_wr[ins_lvl] + 1'b1;
            end
        end

        if (i_cmd.accept_remove) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (any_item && t_level'(l) == sel) begin
                    n_rd[t_level'(l)] = r_rd[t_level'(l)] + 1'b1;
                end else if (!any_item || t_level'(l) > sel) begin
                    n_wr[t_level'(l)] = '0;
                    n_rd[t_level'(l)] = '0;
                end
            end
            if (!any_item) begin
                n_out = '0;
                n_out.status = ST_EMPTY;
            end
        end

        if (i_cmd.load_read) begin
            n_out.status        = ST_OK;
            n_out.item_valid    = 1'b1;
            n_out.item_priority = rdata[r_sel][EW-1 -: PRIO_BITS];
            n_out.item_payload  = WORD_BITS'(rdata[r_sel][PAYLOAD_BITS-1:0]);
        end
    end

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
        tlpq_ram #(
            .WIDTH (EW),
            .DEPTH (LEVEL_DEPTH)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (i_cmd.accept_insert && !ins_full && ins_lvl == t_level'(g)),
            .i_waddr (r_wr[g][AW-1:0]),
            .i_wdata (wdata),
            .i_re    (i_cmd.accept_remove && any_item && sel == t_level'(g)),
            .i_raddr (r_rd[g][AW-1:0]),
            .o_rdata (rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                r_wr[t_level'(l)] <= '0;
                r_rd[t_level'(l)] <= '0;
            end
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.accept_remove) begin
            r_sel <= sel;
        end
    end

    assign o_stat.any_item = any_item;
    assign o_out_data      = r_out;

    `TLPQ_ASSERT_NOW(a_wr_bound, 1'b1, (r_wr[LVL_ONE] <= FULL_MARK) && (r_wr[LVL_TWO] <= FULL_MARK) && (r_wr[LVL_THREE] <= FULL_MARK), "write index beyond depth")
    `TLPQ_ASSERT_NOW(a_rd_le_wr, 1'b1, (r_rd[LVL_ONE] <= r_wr[LVL_ONE]) && (r_rd[LVL_TWO] <= r_wr[LVL_TWO]) && (r_rd[LVL_THREE] <= r_wr[LVL_THREE]), "read index passed write index")
    `TLPQ_ASSERT_NEXT(a_empty_clears, i_cmd.accept_remove && !any_item, (r_wr[LVL_ONE] == '0) && (r_wr[LVL_TWO] == '0) && (r_wr[LVL_THREE] == '0), "empty remove left indices set")

endmodule

>>> rtl/core/tlpq_ctrl.sv
`timescale 1ns / 1ps
`include "three_level_priority_queue_unit_macros.svh"
module tlpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_func,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  tlpq_pkg::t_dp_stat i_stat,
    output tlpq_pkg::t_dp_cmd  o_cmd
);
    import tlpq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   load_now;

    always_comb begin
        o_in_stall = (r_state == S_READ) || (r_out_valid && i_out_stall);
        accept     = i_in_valid && !o_in_stall;

        o_cmd.accept_insert = accept && (i_func == FUNC_INSERT);
        o_cmd.accept_remove = accept && (i_func == FUNC_REMOVE);
        o_cmd.load_read     = (r_state == S_READ);

        load_now = o_cmd.accept_insert || (o_cmd.accept_remove && !i_stat.any_item)
                   || o_cmd.load_read;

        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept_remove && i_stat.any_item) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load_now) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TLPQ_ASSERT_NEXT(a_remove_reads, o_cmd.accept_remove && i_stat.any_item, r_state == S_READ, "remove with item did not start a read")
    `TLPQ_ASSERT_NOW(a_read_slot_free, r_state == S_READ, !r_out_valid, "output register busy when read data returns")
    `TLPQ_ASSERT_NEXT(a_read_delivers, r_state == S_READ, r_out_valid && r_state == S_IDLE, "read result not loaded")

endmodule

>>> rtl/core/three_level_priority_queue_unit.sv
`timescale 1ns / 1ps
// Timing: insert, and a remove that finds every level empty, show their result in the cycle after
// acceptance; a remove that returns an item goes through the store read register first.
// Throughput: one insert per cycle; a remove that returns an item stalls the input during its
// store read. A result held in the output register by i_out_stall holds off the next one.
// Reset: i_rst_n synchronous, active low; clears all indices and control state. Store contents
// are not cleared and no clearing pass runs; the unit accepts transactions right after reset.
module three_level_priority_queue_unit #(
    parameter int LEVEL_DEPTH  = tlpq_pkg::LEVEL_DEPTH_DEF,
    parameter int PAYLOAD_BITS = tlpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tlpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tlpq_pkg::t_out_item o_out_data
);
    import tlpq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in_data.func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tlpq_dp #(
        .LEVEL_DEPTH  (LEVEL_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

endmodule

>>> test/three_level_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
module three_level_priority_queue_unit_tb;
    import tlpq_pkg::*;

    localparam int QDEPTH = LEVEL_DEPTH_DEF;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    three_level_priority_queue_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // predictor state: per-level store and linear indices
    logic [PRIO_BITS+WORD_BITS-1:0] lvl_slot [NUM_LEVELS][QDEPTH];
    int unsigned lvl_wr [NUM_LEVELS];
    int unsigned lvl_rd [NUM_LEVELS];

    t_out_item pending_results [$];
    int err_count      = 0;
    int n_insert_ok    = 0;
    int n_insert_full  = 0;
    int n_served       = 0;
    int n_all_empty    = 0;
    int burst_left     = 0;
    int stall_tick     = 0;
    int stall_mode     = 0;

    typedef struct packed {
        logic                   func;
        logic [PRIO_BITS-1:0]   prio;
        logic [WORD_BITS-1:0]   word;
        logic [4:0]             reps;
        logic                   has_exp;
        logic [STATUS_BITS-1:0] status;
    } t_stim_row;

    localparam int N_ROWS = 14;
    t_stim_row stim_tab [0:N_ROWS-1] = '{
        '{FUNC_REMOVE, 2'd0, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
        '{FUNC_INSERT, 2'd1, 32'h0000_0000, 5'd1,  1'b1, ST_OK},
        '{FUNC_INSERT, 2'd2, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK},
        '{FUNC_INSERT, 2'd3, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_OK},
        '{FUNC_INSERT, 2'd0, 32'h5555_5555, 5'd1,  1'b1, ST_OK},
        '{FUNC_REMOVE, 2'd3, 32'hFFFF_FFFF, 5'd4,  1'b0, ST_OK},
        '{FUNC_REMOVE, 2'd0, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY},
        '{FUNC_INSERT, 2'd2, 32'h8000_0000, 5'd16, 1'b1, ST_OK},
        '{FUNC_INSERT, 2'd2, 32'h1234_5678, 5'd1,  1'b1, ST_FULL},
        '{FUNC_INSERT, 2'd1, 32'h0000_FFFF, 5'd1,  1'b1, ST_OK},
        '{FUNC_REMOVE, 2'd0, 32'h0000_0000, 5'd16, 1'b0, ST_OK},
        // level two drained but indices not yet rewound: still full
        '{FUNC_INSERT, 2'd2, 32'hDEAD_BEEF, 5'd1,  1'b1, ST_FULL},
        '{FUNC_REMOVE, 2'd0, 32'h0000_0000, 5'd1,  1'b0, ST_OK},
        '{FUNC_INSERT, 2'd2, 32'hFEED_F00D, 5'd1,  1'b1, ST_OK}
    };

    function automatic t_out_item predict_queue_op(input t_in_item it);
        t_out_item res;
        t_level    lv;
        res = '0;
        if (it.func == FUNC_INSERT) begin
            lv = (it.priority_req == PRIO_ONE) ? LVL_ONE :
                 (it.priority_req == PRIO_TWO) ? LVL_TWO : LVL_THREE;
            if (lvl_wr[lv] >= QDEPTH) begin
                res.status = ST_FULL;
                n_insert_full++;
            end else begin
                lvl_slot[lv][lvl_wr[lv]] = {it.priority_req, it.payload};
                lvl_wr[lv]++;
                n_insert_ok++;
            end
            return res;
        end
        for (int l = int'(LVL_THREE); l >= int'(LVL_ONE); l--) begin
            if (lvl_wr[l] == lvl_rd[l]) begin
                lvl_wr[l] = 0;
                lvl_rd[l] = 0;
            end else begin
                res.item_valid = 1'b1;
                {res.item_priority, res.item_payload} = lvl_slot[l][lvl_rd[l]];
                lvl_rd[l]++;
                n_served++;
                return res;
            end
        end
        res.status = ST_EMPTY;
        n_all_empty++;
        return res;
    endfunction

    task automatic send_item(input t_in_item it, input logic has_exp,
                             input logic [STATUS_BITS-1:0] exp_status);
        t_out_item model_res;
        t_out_item typed_res;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model_res = predict_queue_op(it);
        if (has_exp) begin
            typed_res        = '0;
            typed_res.status = exp_status;
            pending_results.push_back(typed_res);
        end else begin
            pending_results.push_back(model_res);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic run_random(input int total);
        t_in_item it;
        int done_cnt;
        int seg_len;
        int ins_pct;
        int focus;
        done_cnt = 0;
        while (done_cnt < total) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: ins_pct = 90;
                1: ins_pct = 50;
                default: ins_pct = 15;
            endcase
            focus = $urandom_range(0, 3);
            for (int k = 0; k < seg_len && done_cnt < total; k++) begin
                it.func         = ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE;
                it.priority_req = PRIO_BITS'($urandom_range(0, 3));
                if (focus != 3 && $urandom_range(0, 99) < 80) begin
                    case (focus)
                        0: it.priority_req = PRIO_ONE;
                        1: it.priority_req = PRIO_TWO;
                        default: it.priority_req = $urandom_range(0, 1) ? 2'd3 : 2'd0;
                    endcase
                end
                it.payload = $urandom;
                send_item(it, 1'b0, ST_OK);
                done_cnt++;
            end
            if ($urandom_range(0, 4) == 0) wait_drained();
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: result expected none got %h", $time, got);
            err_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            err_count++;
        end
        if (got.item_valid !== want.item_valid) begin
            $display("%0t: item_valid expected %0d got %0d", $time,
                     want.item_valid, got.item_valid);
            err_count++;
        end
        if (got.item_priority !== want.item_priority) begin
            $display("%0t: item_priority expected %0d got %0d", $time,
                     want.item_priority, got.item_priority);
            err_count++;
        end
        if (got.item_payload !== want.item_payload) begin
            $display("%0t: item_payload expected %h got %h", $time,
                     want.item_payload, got.item_payload);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out_data);
        stall_tick++;
        if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= (stall_tick % 5 < 2);
        endcase
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_in_item it;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            lvl_wr[l] = 0;
            lvl_rd[l] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[r]) begin
            for (int k = 0; k < stim_tab[r].reps; k++) begin
                it.func         = stim_tab[r].func;
                it.priority_req = stim_tab[r].prio;
                it.payload      = stim_tab[r].word + k;
                send_item(it, stim_tab[r].has_exp, stim_tab[r].status);
            end
        end
        wait_drained();

        run_random(1000);
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("summary: %0d inserts stored, %0d refused as full", n_insert_ok, n_insert_full);
        $display("summary: %0d items removed, %0d removes found every level empty",
                 n_served, n_all_empty);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_ram.sv
rtl/core/tlpq_dp.sv
rtl/core/tlpq_ctrl.sv
rtl/core/three_level_priority_queue_unit.sv
test/three_level_priority_queue_unit_tb.sv
